/* sv/timestamp_regression_filter_macros.svh */
// Assertion macros shared by the timestamp regression filter.
// Included by the top level; needs nothing else.
`ifndef TIMESTAMP_REGRESSION_FILTER_MACROS_SVH
`define TIMESTAMP_REGRESSION_FILTER_MACROS_SVH

`define TSF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define TSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* sv/tsf_pkg.sv */
// Shared types and constants of the timestamp regression filter.
// No dependencies.
`default_nettype none

package tsf_pkg;

    localparam int IDX_W         = 32;
    localparam int TS_W          = 48;
    localparam int WLEN_W        = 6;
    localparam int MAXDEV_W      = 32;
    localparam int CFG_ADDR_W    = 4;
    localparam int CFG_DATA_W    = 32;
    localparam int FRACTION_BITS = 20;

    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LENGTH = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_DEVIATION = 4'd1;

    localparam logic [WLEN_W-1:0]   WINDOW_RESET = 6'd20;
    localparam logic [MAXDEV_W-1:0] MAXDEV_RESET = 32'd1 << (FRACTION_BITS - 1);

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [TS_W-1:0]  ts;
    } t_pair;

    typedef struct packed {
        logic clear;
        logic feed;
    } t_acc_ctl;

endpackage

`default_nettype wire

/* sv/tsf_if.sv */
// Handshake channels of the timestamp regression filter: input items,
// result items and register writes. Depends on tsf_pkg.
`default_nettype none

interface tsf_in_if import tsf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] item_index;
    logic [TS_W-1:0]  raw_timestamp;

    modport source (output valid, output item_index, output raw_timestamp, input ready);
    modport sink (input valid, input item_index, input raw_timestamp, output ready);
endinterface

interface tsf_out_if import tsf_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [TS_W-1:0] filtered_timestamp;
    logic            probably_valid;
    logic            fit_used;

    modport source (output valid, output filtered_timestamp, output probably_valid,
                    output fit_used, input ready);
    modport sink (input valid, input filtered_timestamp, input probably_valid,
                  input fit_used, output ready);
endinterface

interface tsf_cfg_if import tsf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

/* sv/tsf_cell.sv */
// One cell of the pair chain: holds an index and a timestamp and loads its
// neighbor's pair when enabled. Depends on tsf_pkg.
`default_nettype none

module tsf_cell import tsf_pkg::*; (
    input  wire   i_clk,
    input  wire   i_en,
    input  t_pair i_pair,
    output t_pair o_pair
);

    t_pair r_pair;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pair <= i_pair;
        end
    end

    assign o_pair = r_pair;

endmodule

`default_nettype wire

/* sv/tsf_accum.sv */
// Three-stage accumulator of the window sums: index offset, products, then
// running sums of u, y, u*u and u*y. Depends on tsf_pkg.
`default_nettype none

module tsf_accum import tsf_pkg::*; #(
    parameter int NW = 6
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  t_acc_ctl            i_ctl,
    input  t_pair               i_pair,
    input  wire [IDX_W-1:0]     i_x,
    output logic [33+NW-1:0]    o_su,
    output logic [48+NW-1:0]    o_sy,
    output logic [64+NW-1:0]    o_suu,
    output logic [81+NW-1:0]    o_suy
);

    localparam int SUW  = 33 + NW;
    localparam int SYW  = 48 + NW;
    localparam int SUUW = 64 + NW;
    localparam int SUYW = 81 + NW;

    logic            r_v1;
    logic [32:0]     r_u1;
    logic [TS_W-1:0] r_y1;
    logic            r_v2;
    logic [32:0]     r_u2;
    logic [TS_W-1:0] r_y2;
    logic [63:0]     r_uu2;
    logic [57:0]     r_uyh2;
    logic [57:0]     r_uyl2;
    logic [SUW-1:0]  r_su;
    logic [SYW-1:0]  r_sy;
    logic [SUUW-1:0] r_suu;
    logic [SUYW-1:0] r_suy;

    logic [32:0]     n_u1;
    logic [65:0]     n_uu;
    logic [57:0]     n_uyh;
    logic [57:0]     n_uyl;
    logic [SUYW-1:0] n_suy;

    assign n_u1  = {1'b0, i_pair.idx} - {1'b0, i_x};
    assign n_uu  = $signed({{33{r_u1[32]}}, r_u1}) * $signed({{33{r_u1[32]}}, r_u1});
    assign n_uyh = $signed({{25{r_u1[32]}}, r_u1}) * $signed({34'b0, r_y1[47:24]});
    assign n_uyl = $signed({{25{r_u1[32]}}, r_u1}) * $signed({34'b0, r_y1[23:0]});
    assign n_suy = r_suy + {{(SUYW-82){r_uyh2[57]}}, r_uyh2, 24'b0}
                 + {{(SUYW-58){r_uyl2[57]}}, r_uyl2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.feed;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u1   <= n_u1;
        r_y1   <= i_pair.ts;
        r_u2   <= r_u1;
        r_y2   <= r_y1;
        r_uu2  <= n_uu[63:0];
        r_uyh2 <= n_uyh;
        r_uyl2 <= n_uyl;
        if (i_ctl.clear) begin
            r_su  <= '0;
            r_sy  <= '0;
            r_suu <= '0;
            r_suy <= '0;
        end else if (r_v2) begin
            r_su  <= r_su + {{(SUW-33){r_u2[32]}}, r_u2};
            r_sy  <= r_sy + {{(SYW-TS_W){1'b0}}, r_y2};
            r_suu <= r_suu + {{(SUUW-64){1'b0}}, r_uu2};
            r_suy <= n_suy;
        end
    end

    assign o_su  = r_su;
    assign o_sy  = r_sy;
    assign o_suu = r_suu;
    assign o_suy = r_suy;

endmodule

`default_nettype wire

/* sv/tsf_mul.sv */
// Shared sequential signed multiplier, four multiplier bits per cycle.
// Depends on tsf_pkg.
`default_nettype none

module tsf_mul import tsf_pkg::*; #(
    parameter int W   = 136,
    parameter int BIW = 57
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_start,
    input  wire [W-1:0]  i_a,
    input  wire [BIW-1:0] i_b,
    output logic         o_done,
    output logic [W-1:0] o_prod
);

    localparam int DIG = (BIW - 1) / 4;
    localparam int CW  = $clog2(DIG);
    localparam int BMW = 4 * DIG;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_am;
    logic [BMW-1:0] r_bm;
    logic          r_neg;
    logic [W-1:0]  r_acc;

    logic [W-1:0]   w_amag;
    logic [BIW-1:0] w_bmag;
    logic [W+3:0]   w_pp;

    assign w_amag = i_a[W-1] ? -i_a : i_a;
    assign w_bmag = i_b[BIW-1] ? -i_b : i_b;
    assign w_pp   = {4'b0, r_am} * {{W{1'b0}}, r_bm[3:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(DIG - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_am  <= w_amag;
            r_bm  <= w_bmag[BMW-1:0];
            r_neg <= i_a[W-1] ^ i_b[BIW-1];
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_neg ? r_acc - w_pp[W-1:0] : r_acc + w_pp[W-1:0];
            r_am  <= {r_am[W-5:0], 4'b0};
            r_bm  <= {4'b0, r_bm[BMW-1:4]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

/* sv/tsf_div.sv */
// Restoring divider for the rounded fit: a range check that flags a quotient
// of 2^48 or more, then one quotient bit per cycle. Depends on tsf_pkg.
`default_nettype none

module tsf_div import tsf_pkg::*; #(
    parameter int W  = 136,
    parameter int RW = 84
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_start,
    input  wire [W-1:0]     i_top,
    input  wire [RW-1:0]    i_bot,
    output logic            o_done,
    output logic            o_sat,
    output logic [TS_W-1:0] o_quot
);

    localparam int CW = $clog2(TS_W);

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic            r_sat;
    logic [RW-1:0]   r_rem;
    logic [TS_W-1:0] r_low;
    logic [TS_W-1:0] r_quot;
    logic [RW-1:0]   r_bot;

    logic [W-1:0]  w_lim;
    logic          w_over;
    logic [RW:0]   w_sh;
    logic          w_ge;
    logic [RW:0]   w_diff;

    assign w_lim  = {{(W-RW-TS_W){1'b0}}, i_bot, {TS_W{1'b0}}};
    assign w_over = i_top >= w_lim;
    assign w_sh   = {r_rem, r_low[TS_W-1]};
    assign w_ge   = w_sh >= {1'b0, r_bot};
    assign w_diff = w_sh - {1'b0, r_bot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= '0;
                if (w_over) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(TS_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sat  <= w_over;
            r_rem  <= i_top[TS_W+RW-1:TS_W];
            r_low  <= i_top[TS_W-1:0];
            r_bot  <= i_bot;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[RW-1:0] : w_sh[RW-1:0];
            r_low  <= {r_low[TS_W-2:0], 1'b0};
            r_quot <= {r_quot[TS_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_sat  = r_sat;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

/* sv/timestamp_regression_filter.sv */
// Top level of the timestamp regression filter: pair chain, sum accumulator,
// shared multiplier, divider and the sequencer. Depends on tsf_pkg, tsf_if,
// tsf_cell, tsf_accum, tsf_mul, tsf_div and the assertion macro header.
//
// Usage: i_item takes (item_index, raw_timestamp) items, o_result gives one
// (filtered_timestamp, probably_valid, fit_used) item for each, in order.
// i_cfg writes window_length (index 0) and max_deviation (index 1) and is
// always ready; write it only while no item is in flight. A window_length
// write empties the window.
// One item is worked on at a time; i_item is ready only when the sequencer
// is idle, also while a finished result waits in the output register.
// Pass-through items go from S_IDLE through S_FIN to the output register. A
// fitted item passes the chain rotation, S_DRAIN, up to seven products through
// the one shared multiplier, S_CHK and, unless the numerator is negative, the
// divider, which forms the 48 quotient bits one at a time. L is the chain
// length (WINDOW_MAX limited to 63) and D = (51 + clog2(L+1)) / 4 is the digit
// count of the shared multiplier.
// Reset empties the window and loads window_length 20 and max_deviation 0.5 s.
// If o_result stalls, the finished item waits in the sequencer and no new
// item is taken until the output register is free.
`default_nettype none
`include "timestamp_regression_filter_macros.svh"

module timestamp_regression_filter import tsf_pkg::*; #(
    parameter int WINDOW_MAX = 32
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    tsf_in_if.sink     i_item,
    tsf_out_if.source  o_result,
    tsf_cfg_if.sink    i_cfg
);

    localparam int LEN_MAX = (WINDOW_MAX < (1 << WLEN_W) - 1) ? WINDOW_MAX
                           : (1 << WLEN_W) - 1;
    localparam int CELLS = LEN_MAX;
    localparam int NW    = $clog2(LEN_MAX + 1);
    localparam int SUW   = 33 + NW;
    localparam int SYW   = 48 + NW;
    localparam int SUUW  = 64 + NW;
    localparam int SUYW  = 81 + NW;
    localparam int W     = 118 + 3 * NW;
    localparam int RW    = 66 + 3 * NW;
    localparam int DIG   = (48 + NW + 3) / 4;
    localparam int BIW   = 4 * DIG + 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ROT    = 4'd1;
    localparam logic [3:0] S_DRAIN  = 4'd2;
    localparam logic [3:0] S_MSTART = 4'd3;
    localparam logic [3:0] S_MWAIT  = 4'd4;
    localparam logic [3:0] S_CHK    = 4'd5;
    localparam logic [3:0] S_DSTART = 4'd6;
    localparam logic [3:0] S_DWAIT  = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    localparam logic [2:0] STEP_N_SUU = 3'd0;
    localparam logic [2:0] STEP_SU_SU = 3'd1;
    localparam logic [2:0] STEP_N_SUY = 3'd2;
    localparam logic [2:0] STEP_SY_SU = 3'd3;
    localparam logic [2:0] STEP_DV_SY = 3'd4;
    localparam logic [2:0] STEP_NC_SU = 3'd5;
    localparam logic [2:0] STEP_N_DV  = 3'd6;

    logic [3:0]          r_state;
    logic [2:0]          r_step;
    logic [NW-1:0]       r_cnt;
    logic [WLEN_W-1:0]   r_window;
    logic [MAXDEV_W-1:0] r_maxdev;
    logic [NW-1:0]       r_filled;
    logic [IDX_W-1:0]    r_x;
    logic [TS_W-1:0]     r_raw;
    logic [W-1:0]        r_t;
    logic [W-1:0]        r_dvar;
    logic [W-1:0]        r_ncov;
    logic [W-1:0]        r_num;
    logic [W-1:0]        r_den;
    logic [TS_W-1:0]     r_f;
    logic                r_fit;
    logic                r_pvt;
    logic                r_out_valid;
    logic [TS_W-1:0]     r_out_f;
    logic                r_out_pv;
    logic                r_out_fit;

    logic [NW-1:0]   w_len;
    logic [NW-1:0]   n_filled;
    logic            w_in_acc;
    logic            w_out_acc;
    logic            w_cfg_acc;
    logic            w_shift;
    logic            w_load_out;
    t_pair           w_head;
    t_pair           w_chain [CELLS];
    t_acc_ctl        w_acc_ctl;
    logic [SUW-1:0]  w_su;
    logic [SYW-1:0]  w_sy;
    logic [SUUW-1:0] w_suu;
    logic [SUYW-1:0] w_suy;
    logic [W-1:0]    w_mul_a;
    logic [BIW-1:0]  w_mul_b;
    logic            w_mul_done;
    logic [W-1:0]    w_mul_p;
    logic [W-1:0]    n_diffp;
    logic            w_div_done;
    logic            w_div_sat;
    logic [TS_W-1:0] w_div_q;
    logic [TS_W-1:0] w_dev;
    logic            w_pv;

    assign w_len = (r_window > WLEN_W'(LEN_MAX)) ? NW'(LEN_MAX) : r_window[NW-1:0];
    assign n_filled = (r_filled < w_len) ? r_filled + NW'(1) : r_filled;

    assign w_in_acc   = i_item.valid && i_item.ready;
    assign w_out_acc  = o_result.valid && o_result.ready;
    assign w_cfg_acc  = i_cfg.valid && i_cfg.ready;
    assign w_load_out = (r_state == S_FIN) && (!r_out_valid || o_result.ready);

    assign i_item.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;

    assign w_shift = (w_in_acc && w_len > NW'(1)) || (r_state == S_ROT);

    always_comb begin
        if (r_state == S_ROT) begin
            w_head = w_chain[CELLS-1];
        end else begin
            w_head.idx = i_item.item_index;
            w_head.ts  = i_item.raw_timestamp;
        end
    end

    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        if (k == 0) begin : g_first
            tsf_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (w_shift),
                .i_pair (w_head),
                .o_pair (w_chain[k])
            );
        end else begin : g_rest
            tsf_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (w_shift),
                .i_pair (w_chain[k-1]),
                .o_pair (w_chain[k])
            );
        end
    end

    assign w_acc_ctl.clear = w_in_acc;
    assign w_acc_ctl.feed  = (r_state == S_ROT)
                          && (({1'b0, r_cnt} + {1'b0, w_len}) >= (NW+1)'(CELLS));

    tsf_accum #(.NW(NW)) u_accum (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_acc_ctl),
        .i_pair (w_chain[CELLS-1]),
        .i_x    (r_x),
        .o_su   (w_su),
        .o_sy   (w_sy),
        .o_suu  (w_suu),
        .o_suy  (w_suy)
    );

    always_comb begin
        case (r_step)
            STEP_N_SUU: begin
                w_mul_a = {{(W-SUUW){1'b0}}, w_suu};
                w_mul_b = {{(BIW-NW){1'b0}}, w_len};
            end
            STEP_SU_SU: begin
                w_mul_a = {{(W-SUW){w_su[SUW-1]}}, w_su};
                w_mul_b = {{(BIW-SUW){w_su[SUW-1]}}, w_su};
            end
            STEP_N_SUY: begin
                w_mul_a = {{(W-SUYW){w_suy[SUYW-1]}}, w_suy};
                w_mul_b = {{(BIW-NW){1'b0}}, w_len};
            end
            STEP_SY_SU: begin
                w_mul_a = {{(W-SYW){1'b0}}, w_sy};
                w_mul_b = {{(BIW-SUW){w_su[SUW-1]}}, w_su};
            end
            STEP_DV_SY: begin
                w_mul_a = r_dvar;
                w_mul_b = {{(BIW-SYW){1'b0}}, w_sy};
            end
            STEP_NC_SU: begin
                w_mul_a = r_ncov;
                w_mul_b = {{(BIW-SUW){w_su[SUW-1]}}, w_su};
            end
            STEP_N_DV: begin
                w_mul_a = r_dvar;
                w_mul_b = {{(BIW-NW){1'b0}}, w_len};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    tsf_mul #(.W(W), .BIW(BIW)) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_state == S_MSTART),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_done (w_mul_done),
        .o_prod (w_mul_p)
    );

    assign n_diffp = r_t - w_mul_p;

    tsf_div #(.W(W), .RW(RW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_state == S_DSTART),
        .i_top  (r_t),
        .i_bot  ({r_den[RW-2:0], 1'b0}),
        .o_done (w_div_done),
        .o_sat  (w_div_sat),
        .o_quot (w_div_q)
    );

    assign w_dev = (r_f > r_raw) ? r_f - r_raw : r_raw - r_f;
    assign w_pv  = r_fit ? (w_dev <= {{(TS_W-MAXDEV_W){1'b0}}, r_maxdev}) : r_pvt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= STEP_N_SUU;
            r_cnt       <= '0;
            r_window    <= WINDOW_RESET;
            r_maxdev    <= MAXDEV_RESET;
            r_filled    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_acc) begin
                case (i_cfg.reg_index)
                    REG_WINDOW_LENGTH: begin
                        r_window <= i_cfg.wdata[WLEN_W-1:0];
                        r_filled <= '0;
                    end
                    REG_MAX_DEVIATION: begin
                        r_maxdev <= i_cfg.wdata[MAXDEV_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (w_len > NW'(1)) begin
                            r_filled <= n_filled;
                        end
                        r_cnt <= '0;
                        if (w_len < NW'(2) || n_filled < w_len) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_ROT;
                        end
                    end
                end
                S_ROT: begin
                    r_cnt <= r_cnt + NW'(1);
                    if (r_cnt == NW'(CELLS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_cnt <= r_cnt + NW'(1);
                    if (r_cnt == NW'(1)) begin
                        r_step  <= STEP_N_SUU;
                        r_state <= S_MSTART;
                    end
                end
                S_MSTART: begin
                    r_state <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (w_mul_done) begin
                        r_step  <= r_step + 3'd1;
                        r_state <= S_MSTART;
                        if (r_step == STEP_SU_SU && n_diffp == '0) begin
                            r_state <= S_FIN;
                        end else if (r_step == STEP_N_DV) begin
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    r_state <= r_num[W-1] ? S_FIN : S_DSTART;
                end
                S_DSTART: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (w_div_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_load_out) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_x   <= i_item.item_index;
                r_raw <= i_item.raw_timestamp;
                r_f   <= i_item.raw_timestamp;
                r_fit <= 1'b0;
                r_pvt <= 1'b1;
            end
            S_MWAIT: begin
                if (w_mul_done) begin
                    case (r_step)
                        STEP_N_SUU: r_t <= w_mul_p;
                        STEP_SU_SU: begin
                            r_dvar <= n_diffp;
                            r_pvt  <= 1'b0;
                        end
                        STEP_N_SUY: r_t <= w_mul_p;
                        STEP_SY_SU: r_ncov <= n_diffp;
                        STEP_DV_SY: r_t <= w_mul_p;
                        STEP_NC_SU: r_num <= n_diffp;
                        STEP_N_DV:  r_den <= w_mul_p;
                        default: begin
                        end
                    endcase
                end
            end
            S_CHK: begin
                r_fit <= 1'b1;
                r_f   <= '0;
                r_t   <= {r_num[W-2:0], 1'b0} + r_den;
            end
            S_DWAIT: begin
                if (w_div_done) begin
                    r_f <= w_div_sat ? {TS_W{1'b1}} : w_div_q;
                end
            end
            default: begin
            end
        endcase
        if (w_load_out) begin
            r_out_f   <= r_f;
            r_out_pv  <= w_pv;
            r_out_fit <= r_fit;
        end
    end

    assign o_result.valid              = r_out_valid;
    assign o_result.filtered_timestamp = r_out_f;
    assign o_result.probably_valid     = r_out_pv;
    assign o_result.fit_used           = r_out_fit;

    `TSF_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_filled <= w_len)
    `TSF_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, w_in_acc, r_state != S_IDLE)
    `TSF_ASSERT_IMP(a_mul_done_in_wait, i_clk, i_rst_n, w_mul_done, r_state == S_MWAIT)
    `TSF_ASSERT_IMP(a_div_done_in_wait, i_clk, i_rst_n, w_div_done, r_state == S_DWAIT)

endmodule

`default_nettype wire

/* test/timestamp_regression_filter_tb.sv */
// Self-checking testbench for the timestamp regression filter: drives item and
// register-write channels, predicts each result with an exact least-squares fit.
// Depends on tsf_pkg, tsf_if and the timestamp_regression_filter RTL.
`default_nettype none

module timestamp_regression_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tsf_pkg::*;

    localparam int                    WMAX       = 32;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 4'd9;
    localparam logic [TS_W-1:0]       TS_MAX     = {TS_W{1'b1}};
    localparam int                    SETTLE_CYC = 400;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle;
    typedef logic signed [255:0] t_wide;

    typedef struct packed {
        logic [TS_W-1:0] ts;
        logic            probably_valid;
        logic            fit_used;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tsf_in_if  item_ch();
    tsf_out_if result_ch();
    tsf_cfg_if cfg_ch();

    timestamp_regression_filter #(.WINDOW_MAX(WMAX)) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    always #10 i_clk = ~i_clk;

    t_pair   pending_items[$];
    t_result expected_results[$];
    t_idle   idle_mode = IDLE_NONE;
    int      mismatches = 0;

    logic [IDX_W-1:0]    ring_idx[WMAX];
    logic [TS_W-1:0]     ring_ts[WMAX];
    int unsigned         next_slot;
    int unsigned         stored_pairs;
    logic [WLEN_W-1:0]   win_len;
    logic [MAXDEV_W-1:0] dev_limit;

    function automatic t_result predict_timestamp(t_pair p);
        int unsigned len;
        int unsigned s;
        t_wide n, su, sy, suu, suy, u, y, dvar, ncov, num, den, q;
        logic [TS_W-1:0] f, diff;
        t_result r;
        len = (win_len > WMAX) ? WMAX : win_len;
        if (len > 1) begin
            s = (next_slot < len) ? next_slot : 0;
            ring_idx[s] = p.idx;
            ring_ts[s] = p.ts;
            if (stored_pairs < len) stored_pairs++;
            s++;
            next_slot = (s >= len) ? 0 : s;
        end
        if (len < 2 || stored_pairs < len) begin
            r.ts = p.ts;
            r.probably_valid = 1'b1;
            r.fit_used = 1'b0;
            return r;
        end
        n = len;
        su = 0; sy = 0; suu = 0; suy = 0;
        for (int i = 0; i < len; i++) begin
            u = ring_idx[i];
            y = p.idx;
            u = u - y;
            y = ring_ts[i];
            su = su + u;
            sy = sy + y;
            suu = suu + u * u;
            suy = suy + u * y;
        end
        dvar = n * suu - su * su;
        if (dvar == 0) begin
            r.ts = p.ts;
            r.probably_valid = 1'b0;
            r.fit_used = 1'b0;
            return r;
        end
        ncov = n * suy - su * sy;
        num = sy * dvar - ncov * su;
        den = n * dvar;
        if (num < 0) begin
            f = '0;
        end else begin
            q = (2 * num + den) / (2 * den);
            f = (q > TS_MAX) ? TS_MAX : q[TS_W-1:0];
        end
        diff = (f > p.ts) ? f - p.ts : p.ts - f;
        r.ts = f;
        r.probably_valid = (diff <= dev_limit);
        r.fit_used = 1'b1;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_pair p;
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                p.idx = item_ch.item_index;
                p.ts = item_ch.raw_timestamp;
                expected_results.insert(expected_results.size(), predict_timestamp(p));
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (pending_items.size() > 0 &&
                    !((idle_mode == IDLE_SENDER && $urandom_range(99) < 73) ||
                      (idle_mode == IDLE_BOTH && $urandom_range(99) < 22))) begin
                    p = pending_items.pop_front();
                    item_ch.item_index <= p.idx;
                    item_ch.raw_timestamp <= p.ts;
                    item_ch.valid <= 1'b1;
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                got.ts = result_ch.filtered_timestamp;
                got.probably_valid = result_ch.probably_valid;
                got.fit_used = result_ch.fit_used;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result item: ts=%h valid=%b fit=%b",
                                 got.ts, got.probably_valid, got.fit_used);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected ts=%h valid=%b fit=%b, got ts=%h valid=%b fit=%b",
                                     want.ts, want.probably_valid, want.fit_used,
                                     got.ts, got.probably_valid, got.fit_used);
                    end
                end
            end
            result_ch.ready <= !((idle_mode == IDLE_RECEIVER && $urandom_range(99) < 73) ||
                                 (idle_mode == IDLE_BOTH && $urandom_range(99) < 22));
        end
    end

    task automatic add_item(input logic [IDX_W-1:0] idx, input logic [TS_W-1:0] ts);
        t_pair p;
        p.idx = idx;
        p.ts = ts;
        pending_items.insert(pending_items.size(), p);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_items.size() > 0 || item_ch.valid || expected_results.size() > 0);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] ri, input logic [CFG_DATA_W-1:0] wd);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.reg_index <= ri;
        cfg_ch.wdata <= wd;
        forever begin
            @(posedge i_clk);
            if (cfg_ch.ready) break;
        end
        cfg_ch.valid <= 1'b0;
        if (ri == REG_WINDOW_LENGTH) begin
            win_len = wd[WLEN_W-1:0];
            next_slot = 0;
            stored_pairs = 0;
        end else if (ri == REG_MAX_DEVIATION) begin
            dev_limit = wd;
        end
    endtask

    task automatic add_random_phase(input int count, input int unsigned wl);
        logic [IDX_W-1:0] idx;
        logic [63:0] base;
        int unsigned period, jitter, run;
        int added;
        added = 0;
        while (added < count) begin
            case ($urandom_range(9))
                0: begin
                    add_item($urandom, TS_W'({$urandom, $urandom}));
                    added++;
                end
                1: begin
                    idx = $urandom;
                    add_item(idx, TS_W'({$urandom, $urandom}));
                    add_item(idx + $urandom_range(1, 1000000), TS_W'($urandom));
                    added += 2;
                end
                default: begin
                    idx = ($urandom_range(3) == 0) ? $urandom : $urandom_range(100000);
                    base = ($urandom_range(3) == 0) ? {$urandom, $urandom} & (TS_MAX >> 1)
                                                   : $urandom;
                    period = $urandom_range(20000, 60000);
                    jitter = ($urandom_range(3) == 0) ? $urandom_range(1 << 21) : $urandom_range(4000);
                    run = $urandom_range(1, 2 * wl + 2);
                    for (int k = 0; k < run; k++) begin
                        add_item(idx, TS_W'(base + $urandom_range(jitter)));
                        if ($urandom_range(7) == 0) begin
                            idx += $urandom_range(2, 4);
                            base += 3 * period;
                        end else begin
                            idx += 1;
                            base += period;
                        end
                    end
                    added += run;
                end
            endcase
        end
    endtask

    initial begin
        int unsigned wl;
        logic [CFG_DATA_W-1:0] dv;
        item_ch.valid = 1'b0;
        item_ch.item_index = '0;
        item_ch.raw_timestamp = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.reg_index = REG_WINDOW_LENGTH;
        cfg_ch.wdata = '0;
        result_ch.ready = 1'b0;
        win_len = WINDOW_RESET;
        dev_limit = MAXDEV_RESET;
        next_slot = 0;
        stored_pairs = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        add_item('0, '0);
        add_item('1, TS_MAX);
        add_item(32'h5555_5555, 48'hAAAA_AAAA_AAAA);
        wait_drained();
        write_reg(REG_WINDOW_LENGTH, 3);
        @(negedge i_clk);
        add_item(10, 48'h4000_0000_0000);
        add_item(11, '0);
        add_item(12, '0);
        wait_drained();
        write_reg(REG_WINDOW_LENGTH, 3);
        @(negedge i_clk);
        add_item(10, '0);
        add_item(11, TS_MAX);
        add_item(12, TS_MAX);
        wait_drained();
        write_reg(REG_WINDOW_LENGTH, 2);
        write_reg(REG_MAX_DEVIATION, 0);
        @(negedge i_clk);
        add_item(7, 48'd1000);
        add_item(7, 48'd2000);
        add_item('1, 48'd3000);
        add_item(0, 48'd4000);
        wait_drained();
        write_reg(REG_WINDOW_LENGTH, 1);
        write_reg(REG_UNUSED, '1);
        @(negedge i_clk);
        add_item(1, 48'd5);
        add_item(2, 48'd6);
        wait_drained();
        write_reg(REG_WINDOW_LENGTH, 0);
        write_reg(REG_MAX_DEVIATION, '1);
        @(negedge i_clk);
        add_item(3, 48'd7);
        wait_drained();
        write_reg(REG_WINDOW_LENGTH, 63);
        @(negedge i_clk);
        for (int k = 0; k < 34; k++) add_item(100 + k, 48'd1000 + 48'd35000 * k + k[0]);
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: wl = 2;
                1: wl = 32;
                2: wl = 5;
                3: wl = 63;
                4: wl = 20;
                5: wl = 3;
                default: wl = $urandom_range(0, 63);
            endcase
            case ($urandom_range(3))
                0: dv = 0;
                1: dv = '1;
                2: dv = MAXDEV_RESET;
                default: dv = $urandom_range(1 << 22);
            endcase
            write_reg(REG_WINDOW_LENGTH, wl);
            write_reg(REG_MAX_DEVIATION, dv);
            @(negedge i_clk);
            idle_mode <= t_idle'(ph % 4);
            add_random_phase(125, (wl > WMAX) ? WMAX : wl);
            wait_drained();
        end

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
